### hdl/dee_pkg.sv
// Shared constants and types for the disparity error evaluator.
package dee_pkg;

    localparam int PIXEL_COUNT_BITS = 22;
    localparam int DISP_FRAC_BITS   = 8;

    localparam int DISP_W  = 18;
    localparam int SUM_W   = 40;
    localparam int CNT_W   = 23;
    localparam int MEAN_W  = 18;
    localparam int COLOR_W = 8;
    localparam int SCALE_W = 7;
    localparam int PROD_W  = DISP_W + SCALE_W;

    localparam int COUNT_LIM_BITS = (PIXEL_COUNT_BITS + 1 > CNT_W) ? CNT_W : PIXEL_COUNT_BITS + 1;
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'((64'd1 << COUNT_LIM_BITS) - 64'd1);
    localparam logic [SUM_W-1:0]   SUM_MAX  = '1;
    localparam logic [MEAN_W-1:0]  MEAN_MAX = '1;

    localparam logic [SCALE_W-1:0] SHADE_SCALE = SCALE_W'(100);
    localparam logic [COLOR_W-1:0] FULL        = COLOR_W'(255);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        CLS_INVALID,
        CLS_UNKNOWN,
        CLS_VALID
    } pixel_class_t;

    typedef struct packed {
        pixel_class_t       cls;
        logic [DISP_W-1:0]  err;
        logic               truth_gt;
        logic               last;
    } item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### hdl/dee_front.sv
// Front end: accept a pixel pair, classify it and form the absolute error.
module dee_front (
    input  logic                         push,
    output logic                         full,
    input  logic signed [dee_pkg::DISP_W-1:0] computed_disparity,
    input  logic signed [dee_pkg::DISP_W-1:0] truth_disparity,
    input  logic                         frame_end,
    input  logic                         fifo_full,
    output logic                         fifo_wr,
    output dee_pkg::item_t               fifo_item
);

    logic signed [dee_pkg::DISP_W:0] diff;
    logic signed [dee_pkg::DISP_W:0] diff_abs;
    logic                            comp_pos;

    assign full    = fifo_full;
    assign fifo_wr = push && !fifo_full;

    always_comb
    begin
        diff     = {truth_disparity[dee_pkg::DISP_W-1], truth_disparity}
                 - {computed_disparity[dee_pkg::DISP_W-1], computed_disparity};
        diff_abs = diff[dee_pkg::DISP_W] ? -diff : diff;
        comp_pos = !computed_disparity[dee_pkg::DISP_W-1] && (|computed_disparity);

        fifo_item.err      = diff_abs[dee_pkg::DISP_W-1:0];
        fifo_item.truth_gt = !diff[dee_pkg::DISP_W] && (|diff);
        fifo_item.last     = frame_end;
        if (!comp_pos)
        begin
            fifo_item.cls = dee_pkg::CLS_INVALID;
        end
        else if (truth_disparity == '0)
        begin
            fifo_item.cls = dee_pkg::CLS_UNKNOWN;
        end
        else
        begin
            fifo_item.cls = dee_pkg::CLS_VALID;
        end
    end

endmodule

### hdl/dee_fifo.sv
// Short queue of classified pixels between the front and back ends.
module dee_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  dee_pkg::item_t wr_item,
    input  logic           rd,
    output dee_pkg::item_t rd_item,
    output logic           fifo_full,
    output logic           fifo_empty
);

    dee_pkg::item_t                     slot_reg [dee_pkg::FIFO_DEPTH];
    logic [dee_pkg::FIFO_PTR_W-1:0]     wr_ptr_reg;
    logic [dee_pkg::FIFO_PTR_W-1:0]     rd_ptr_reg;
    logic [dee_pkg::FIFO_CNT_W-1:0]     count_reg;
    logic [dee_pkg::FIFO_CNT_W-1:0]     count_next;

    assign fifo_full  = (count_reg == dee_pkg::FIFO_CNT_W'(dee_pkg::FIFO_DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign rd_item    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == dee_pkg::FIFO_PTR_W'(dee_pkg::FIFO_DEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == dee_pkg::FIFO_PTR_W'(dee_pkg::FIFO_DEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### hdl/dee_divider.sv
// Restoring divider, one quotient bit per cycle, for the frame mean.
module dee_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dee_pkg::SUM_W-1:0]   dividend,
    input  logic [dee_pkg::CNT_W-1:0]   divisor,
    output logic [dee_pkg::SUM_W-1:0]   quotient,
    output dee_pkg::div_stat_t          stat
);

    logic [dee_pkg::SUM_W-1:0]     quo_reg;
    logic [dee_pkg::CNT_W-1:0]     rem_reg;
    logic [dee_pkg::CNT_W-1:0]     dsr_reg;
    logic [dee_pkg::DIV_CNT_W-1:0] step_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [dee_pkg::CNT_W:0]       rem_shift;
    logic [dee_pkg::CNT_W+1:0]     trial;
    logic                          fits;
    logic [dee_pkg::CNT_W-1:0]     rem_next;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[dee_pkg::SUM_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, dsr_reg};
        fits      = !trial[dee_pkg::CNT_W+1];
        rem_next  = fits ? trial[dee_pkg::CNT_W-1:0] : rem_shift[dee_pkg::CNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[dee_pkg::SUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == dee_pkg::DIV_CNT_W'(dee_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### hdl/dee_back.sv
// Back end: colour each pixel, keep the frame totals and hold the result.
module dee_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fifo_empty,
    input  dee_pkg::item_t               head,
    output logic                         fifo_rd,
    output logic                         div_start,
    output logic [dee_pkg::SUM_W-1:0]    div_dividend,
    output logic [dee_pkg::CNT_W-1:0]    div_divisor,
    input  logic [dee_pkg::SUM_W-1:0]    div_quotient,
    input  dee_pkg::div_stat_t           div_stat,
    input  logic                         pop,
    output logic                         empty,
    output logic [dee_pkg::COLOR_W-1:0]  color_blue,
    output logic [dee_pkg::COLOR_W-1:0]  color_green,
    output logic [dee_pkg::COLOR_W-1:0]  color_red,
    output logic                         summary_ready,
    output logic [dee_pkg::MEAN_W-1:0]   mean_error,
    output logic [dee_pkg::CNT_W-1:0]    valid_pixels,
    output logic [dee_pkg::CNT_W-1:0]    invalid_pixels,
    output logic                         no_valid_pixels
);

    typedef enum logic {
        ST_RUN,
        ST_DIV
    } back_state_t;

    back_state_t                 state_reg;
    logic [dee_pkg::SUM_W-1:0]   sum_reg;
    logic [dee_pkg::CNT_W-1:0]   vcnt_reg;
    logic [dee_pkg::CNT_W-1:0]   icnt_reg;
    logic [dee_pkg::CNT_W-1:0]   vhold_reg;
    logic [dee_pkg::CNT_W-1:0]   ihold_reg;
    logic [dee_pkg::COLOR_W-1:0] bhold_reg, ghold_reg, rhold_reg;

    logic                        out_valid_reg;
    logic [dee_pkg::COLOR_W-1:0] blue_reg, green_reg, red_reg;
    logic                        summary_reg;
    logic [dee_pkg::MEAN_W-1:0]  mean_reg;
    logic [dee_pkg::CNT_W-1:0]   valid_reg;
    logic [dee_pkg::CNT_W-1:0]   invalid_reg;
    logic                        novalid_reg;

    logic                        out_free;
    logic                        out_load;
    logic                        take;
    logic                        pixel_ok;
    logic [dee_pkg::PROD_W-1:0]  prod;
    logic [dee_pkg::PROD_W-1:0]  shade_wide;
    logic [dee_pkg::COLOR_W-1:0] shade;
    logic [dee_pkg::COLOR_W-1:0] b_next, g_next, r_next;
    logic [dee_pkg::SUM_W:0]     sum_add;
    logic [dee_pkg::SUM_W-1:0]   sum_next;
    logic [dee_pkg::CNT_W-1:0]   vcnt_next;
    logic [dee_pkg::CNT_W-1:0]   icnt_next;
    logic [dee_pkg::MEAN_W-1:0]  mean_next;

    assign out_free = !out_valid_reg || pop;
    assign take     = (state_reg == ST_RUN) && !fifo_empty && out_free;
    assign fifo_rd  = take;
    assign pixel_ok = (head.cls == dee_pkg::CLS_VALID);
    // a plain pixel or a finished summary fills the result register
    assign out_load = (take && !head.last)
                   || ((state_reg == ST_DIV) && div_stat.done && out_free);

    always_comb
    begin
        prod       = dee_pkg::PROD_W'(head.err) * dee_pkg::PROD_W'(dee_pkg::SHADE_SCALE);
        shade_wide = prod >> dee_pkg::DISP_FRAC_BITS;
        shade      = (shade_wide > dee_pkg::PROD_W'(dee_pkg::FULL))
                   ? dee_pkg::FULL : shade_wide[dee_pkg::COLOR_W-1:0];

        b_next = dee_pkg::FULL;
        g_next = dee_pkg::FULL;
        r_next = dee_pkg::FULL;
        if (pixel_ok)
        begin
            g_next = dee_pkg::FULL - shade;
            if (head.truth_gt)
            begin
                r_next = dee_pkg::FULL - shade;
            end
            else
            begin
                b_next = dee_pkg::FULL - shade;
            end
        end

        sum_add   = {1'b0, sum_reg} + dee_pkg::SUM_W'(head.err);
        sum_next  = sum_reg;
        vcnt_next = vcnt_reg;
        icnt_next = icnt_reg;
        case (head.cls)
            dee_pkg::CLS_VALID:
            begin
                sum_next = sum_add[dee_pkg::SUM_W] ? dee_pkg::SUM_MAX
                                                   : sum_add[dee_pkg::SUM_W-1:0];
                if (vcnt_reg < dee_pkg::COUNT_MAX)
                begin
                    vcnt_next = vcnt_reg + 1'b1;
                end
            end
            dee_pkg::CLS_INVALID:
            begin
                if (icnt_reg < dee_pkg::COUNT_MAX)
                begin
                    icnt_next = icnt_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        mean_next = (|div_quotient[dee_pkg::SUM_W-1:dee_pkg::MEAN_W])
                  ? dee_pkg::MEAN_MAX : div_quotient[dee_pkg::MEAN_W-1:0];
    end

    assign div_start    = take && head.last;
    assign div_dividend = sum_next;
    assign div_divisor  = vcnt_next;

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            vhold_reg <= vcnt_next;
            ihold_reg <= icnt_next;
            bhold_reg <= b_next;
            ghold_reg <= g_next;
            rhold_reg <= r_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            sum_reg       <= '0;
            vcnt_reg      <= '0;
            icnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            blue_reg      <= '0;
            green_reg     <= '0;
            red_reg       <= '0;
            summary_reg   <= 1'b0;
            mean_reg      <= '0;
            valid_reg     <= '0;
            invalid_reg   <= '0;
            novalid_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_RUN:
                begin
                    if (take && head.last)
                    begin
                        sum_reg   <= '0;
                        vcnt_reg  <= '0;
                        icnt_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                    else if (take)
                    begin
                        sum_reg       <= sum_next;
                        vcnt_reg      <= vcnt_next;
                        icnt_reg      <= icnt_next;
                        blue_reg      <= b_next;
                        green_reg     <= g_next;
                        red_reg       <= r_next;
                        summary_reg   <= 1'b0;
                        mean_reg      <= '0;
                        valid_reg     <= '0;
                        invalid_reg   <= '0;
                        novalid_reg   <= 1'b0;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done && out_free)
                    begin
                        blue_reg      <= bhold_reg;
                        green_reg     <= ghold_reg;
                        red_reg       <= rhold_reg;
                        summary_reg   <= 1'b1;
                        mean_reg      <= (vhold_reg == '0) ? '0 : mean_next;
                        valid_reg     <= vhold_reg;
                        invalid_reg   <= ihold_reg;
                        novalid_reg   <= (vhold_reg == '0);
                        state_reg     <= ST_RUN;
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    assign empty           = !out_valid_reg;
    assign color_blue      = blue_reg;
    assign color_green     = green_reg;
    assign color_red       = red_reg;
    assign summary_ready   = summary_reg;
    assign mean_error      = mean_reg;
    assign valid_pixels    = valid_reg;
    assign invalid_pixels  = invalid_reg;
    assign no_valid_pixels = novalid_reg;

    a_no_pop_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> !fifo_rd)
        else $error("queue read during frame division");

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_novalid_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && novalid_reg) |-> (mean_reg == '0 && summary_reg))
        else $error("empty frame summary carries a mean");

    a_summary_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(summary_reg) && out_valid_reg) |-> $past(state_reg == ST_DIV))
        else $error("summary shown without a division");

    a_counts_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (vcnt_reg == '0 && icnt_reg == '0 && sum_reg == '0))
        else $error("frame totals not cleared after frame end");

endmodule

### hdl/disparity_error_evaluator.sv
// Top level of the disparity error evaluator: front end, queue, back end and divider.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------------
//  pixel in | push / full  (push & !full)| computed_disparity, truth_disparity,
//           |                            | frame_end
//  result   | empty / pop  (pop & !empty)| color_blue/green/red, summary_ready,
//           |                            | mean_error, valid_pixels, invalid_pixels,
//           |                            | no_valid_pixels
//
// Flow: one pixel request per cycle while full is low; a result passes through the queue
// slot and then the result register. The frame's last pixel starts the restoring divider,
// one quotient bit of the mean per cycle, and the summary loads once it is done and the result register is free.
// Reset: rst_n clears the queue, the frame totals and the result register at once.
// Stalls: a four-entry queue parts the front from the back, so pixels keep arriving
// while a result waits on pop or the mean is being divided; full rises when it fills.
module disparity_error_evaluator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [dee_pkg::DISP_W-1:0]   computed_disparity,
    input  logic signed [dee_pkg::DISP_W-1:0]   truth_disparity,
    input  logic                                frame_end,
    output logic                                empty,
    input  logic                                pop,
    output logic [dee_pkg::COLOR_W-1:0]         color_blue,
    output logic [dee_pkg::COLOR_W-1:0]         color_green,
    output logic [dee_pkg::COLOR_W-1:0]         color_red,
    output logic                                summary_ready,
    output logic [dee_pkg::MEAN_W-1:0]          mean_error,
    output logic [dee_pkg::CNT_W-1:0]           valid_pixels,
    output logic [dee_pkg::CNT_W-1:0]           invalid_pixels,
    output logic                                no_valid_pixels
);

    // queue between front and back
    logic                       fifo_full;
    logic                       fifo_empty;
    logic                       fifo_wr;
    logic                       fifo_rd;
    dee_pkg::item_t             wr_item;
    dee_pkg::item_t             rd_item;

    // divider hookup
    logic                       div_start;
    logic [dee_pkg::SUM_W-1:0]  div_dividend;
    logic [dee_pkg::CNT_W-1:0]  div_divisor;
    logic [dee_pkg::SUM_W-1:0]  div_quotient;
    dee_pkg::div_stat_t         div_stat;

    // classify each request and form its absolute error
    dee_front u_front (
        .push               (push),
        .full               (full),
        .computed_disparity (computed_disparity),
        .truth_disparity    (truth_disparity),
        .frame_end          (frame_end),
        .fifo_full          (fifo_full),
        .fifo_wr            (fifo_wr),
        .fifo_item          (wr_item)
    );

    // hold classified pixels until the back end is free
    dee_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (fifo_wr),
        .wr_item    (wr_item),
        .rd         (fifo_rd),
        .rd_item    (rd_item),
        .fifo_full  (fifo_full),
        .fifo_empty (fifo_empty)
    );

    // mean of the frame: error sum over valid count
    dee_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // colour, accumulate and drive the result register
    dee_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .fifo_empty      (fifo_empty),
        .head            (rd_item),
        .fifo_rd         (fifo_rd),
        .div_start       (div_start),
        .div_dividend    (div_dividend),
        .div_divisor     (div_divisor),
        .div_quotient    (div_quotient),
        .div_stat        (div_stat),
        .pop             (pop),
        .empty           (empty),
        .color_blue      (color_blue),
        .color_green     (color_green),
        .color_red       (color_red),
        .summary_ready   (summary_ready),
        .mean_error      (mean_error),
        .valid_pixels    (valid_pixels),
        .invalid_pixels  (invalid_pixels),
        .no_valid_pixels (no_valid_pixels)
    );

endmodule
